>>> sv/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test unit.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;
	localparam int FIELD_W    = 12;
	localparam int COUNT_W    = 7;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DRAIN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} edge_ctrl_t;

	typedef struct packed {
		logic busy;
		logic parity;
	} edge_stat_t;

endpackage

>>> sv/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared edge evaluator: one polygon edge per cycle, straddle test and
// sign-aware cross-multiplication, folding the crossing parity.
// ----------------------------------------------------------------------------
module pip_edge_unit
	import pip_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  edge_ctrl_t            ctrl,
	input  logic [COORD_BITS-1:0] cur_col,
	input  logic [COORD_BITS-1:0] cur_row,
	input  logic [COORD_BITS-1:0] prev_col,
	input  logic [COORD_BITS-1:0] prev_row,
	input  logic [COORD_BITS-1:0] pt_col,
	input  logic [COORD_BITS-1:0] pt_row,
	output edge_stat_t            stat
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic                 straddle;
	logic                 den_pos;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] ex;
	logic signed [DW-1:0] den;
	logic signed [PW-1:0] lhs_d;
	logic signed [PW-1:0] rhs_d;

	logic                 v_s1;
	logic                 cand_s1;
	logic                 pos_s1;
	logic signed [PW-1:0] lhs_s1;
	logic signed [PW-1:0] rhs_s1;
	logic                 parity_q;
	logic                 hit;

	always_comb begin
		straddle = ((cur_row < pt_row) && (prev_row >= pt_row)) ||
		           ((prev_row < pt_row) && (cur_row >= pt_row));
		den_pos  = prev_row > cur_row;
		dy       = $signed({1'b0, pt_row}) - $signed({1'b0, cur_row});
		dx       = $signed({1'b0, prev_col}) - $signed({1'b0, cur_col});
		ex       = $signed({1'b0, pt_col}) - $signed({1'b0, cur_col});
		den      = $signed({1'b0, prev_row}) - $signed({1'b0, cur_row});
		lhs_d    = PW'(dy) * PW'(dx);
		rhs_d    = PW'(ex) * PW'(den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		cand_s1 <= straddle;
		pos_s1  <= den_pos;
		lhs_s1  <= lhs_d;
		rhs_s1  <= rhs_d;
	end

	assign hit = v_s1 && cand_s1 && (pos_s1 ? (lhs_s1 < rhs_s1) : (lhs_s1 > rhs_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
		end else if (ctrl.clear) begin
			parity_q <= 1'b0;
		end else if (hit) begin
			parity_q <= ~parity_q;
		end
	end

	assign stat.busy   = v_s1;
	assign stat.parity = parity_q;

endmodule

>>> sv/point_in_polygon_test_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Polygon vertex store with crossing-number point queries.
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// s_axis   in   tuser: mode; tdata: x, y
// m_axis   out  tdata: inside_res, vertex_count, overflow
//
// Clear, append and idle codes go from accept straight to the response state.
// A query first reads the last held vertex, then the walk reads one vertex per
// cycle from the vertex memory and the shared edge unit evaluates one edge per
// cycle.
// One beat is in flight at a time; a result waits in the output register
// while m_axis stalls. Reset empties the polygon.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // x, y
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // inside_res, vertex_count, overflow, pad
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int VW = 2 * FIELD_W;

	state_t                state_q;
	state_t                state_d;
	mode_t                 in_mode;
	mode_t                 mode_q;
	logic [FIELD_W-1:0]    in_col;
	logic [FIELD_W-1:0]    in_row;
	logic [FIELD_W-1:0]    px_q;
	logic [FIELD_W-1:0]    py_q;
	logic [CW-1:0]         held_count_q;
	logic                  has_room;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         last_idx;
	logic [AW-1:0]         raddr;
	logic                  rd_en;
	logic                  rd_vld_q;
	logic                  rd_prime_q;
	logic [VW-1:0]         mem [MAX_VERTICES];
	logic [VW-1:0]         rd_q;
	logic [VW-1:0]         prev_q;
	logic                  ovf_q;
	logic                  accept;
	logic                  load_out;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	edge_ctrl_t            edge_ctrl;
	edge_stat_t            edge_stat;

	assign in_mode  = mode_t'(s_axis_tuser);
	assign in_col   = s_axis_tdata[FIELD_W-1:0];
	assign in_row   = s_axis_tdata[2*FIELD_W-1:FIELD_W];
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign has_room = held_count_q < CW'(MAX_VERTICES);
	assign last_idx = AW'(held_count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		s_axis_tready   = 1'b0;
		raddr           = idx_q;
		rd_en           = 1'b0;
		load_out        = 1'b0;
		edge_ctrl.clear = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					edge_ctrl.clear = 1'b1;
					if (in_mode == MODE_QUERY && held_count_q != '0) begin
						state_d = ST_PRIME;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_PRIME: begin
				raddr   = last_idx;
				rd_en   = 1'b1;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_vld_q && !edge_stat.busy) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		edge_ctrl.valid = rd_vld_q && !rd_prime_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			idx_q        <= '0;
			ovf_q        <= 1'b0;
			rd_vld_q     <= 1'b0;
			rd_prime_q   <= 1'b0;
		end else begin
			rd_vld_q   <= rd_en;
			rd_prime_q <= state_q == ST_PRIME;
			if (accept) begin
				idx_q <= '0;
				ovf_q <= 1'b0;
				case (in_mode)
					MODE_CLEAR: held_count_q <= '0;
					MODE_APPEND: begin
						if (has_room) begin
							held_count_q <= held_count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end else if (state_q == ST_WALK) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= in_mode;
			px_q   <= in_col;
			py_q   <= in_row;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_mode == MODE_APPEND && has_room) begin
			mem[held_count_q[AW-1:0]] <= {in_row, in_col};
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
		if (rd_vld_q) begin
			prev_q <= rd_q;
		end
	end

	pip_edge_unit #(
		.COORD_BITS(FIELD_W)
	) u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (edge_ctrl),
		.cur_col (rd_q[FIELD_W-1:0]),
		.cur_row (rd_q[VW-1:FIELD_W]),
		.prev_col(prev_q[FIELD_W-1:0]),
		.prev_row(prev_q[VW-1:FIELD_W]),
		.pt_col  (px_q),
		.pt_row  (py_q),
		.stat    (edge_stat)
	);

	// hold the result until the sink takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {(OUT_DATA_W - COUNT_W - 2)'(0), ovf_q,
			             COUNT_W'(held_count_q), edge_stat.parity};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CW'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second beat taken while one is in flight");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !rd_vld_q && !edge_stat.busy)
		else $error("edge pipeline active while idle");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && ovf_q |-> mode_q == MODE_APPEND && held_count_q == CW'(MAX_VERTICES))
		else $error("overflow flagged without a full store");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> idx_q <= last_idx)
		else $error("walk index past last vertex");
`endif

endmodule
